FILE: design/glpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package glpd_pkg;

  // configuration register width and reset value
  localparam int CFG_W = 11;
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // width of the row and column fields of a result
  localparam int RES_W = 10;

  // a single pixel can decide up to three pixels
  localparam int PUSH_MAX = 3;
  localparam int PUSH_CNT_W = 2;

  // result queue depth
  localparam int QUEUE_DEPTH = 8;

  typedef enum logic {
    REG_FRAME_ROWS = 1'b0,
    REG_FRAME_COLS = 1'b1
  } glpd_reg_t;

  typedef struct packed {
    logic [RES_W-1:0] row;
    logic [RES_W-1:0] col;
    logic             last;
  } glpd_result_t;

  typedef struct packed {
    logic [PUSH_CNT_W-1:0]             n;
    glpd_result_t [PUSH_MAX-1:0]       ent;
  } glpd_push_t;

  // frame size as used: below two acts as two, above the maximum acts as the maximum
  function automatic logic [31:0] clamp_count(input logic [CFG_W-1:0] raw,
                                              input logic [31:0] max_n);
    logic [31:0] v;
    v = 32'(raw);
    if (v < 32'd2) begin
      return 32'd2;
    end
    if (v > max_n) begin
      return max_n;
    end
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: design/glpd_col_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// one column of the 3-high window: two rows above and the current row
module glpd_col_cell #(
  parameter int W = 16
) (
  input  wire                  clk,
  input  wire                  shift,
  input  wire signed [W-1:0]   top_in,
  input  wire signed [W-1:0]   mid_in,
  input  wire signed [W-1:0]   bot_in,
  output logic signed [W-1:0]  top,
  output logic signed [W-1:0]  mid,
  output logic signed [W-1:0]  bot
);

  always_ff @(posedge clk) begin
    if (shift) begin
      top <= top_in;
      mid <= mid_in;
      bot <= bot_in;
    end
  end

endmodule

`default_nettype wire

FILE: design/glpd_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

// one write port, one registered read port, write data bypassed on a same-address read
module glpd_line_buf #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire                       re,
  input  wire [$clog2(DEPTH)-1:0]   raddr,
  output logic [WIDTH-1:0]          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      if (we && waddr == raddr) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/glpd_result_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// small result fifo, up to three pushes per cycle, one pop per cycle
module glpd_result_queue (
  input  wire                       clk,
  input  wire                       rst,
  input  wire glpd_pkg::glpd_push_t push,
  output logic                      room,
  output logic                      out_valid,
  input  wire                       out_ready,
  output glpd_pkg::glpd_result_t    head
);

  import glpd_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int AW = $clog2(DEPTH);

  glpd_result_t   slots [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [AW:0]    count;
  logic           pop;

  assign out_valid = (count != '0);
  assign pop = out_valid && out_ready;
  assign head = slots[rptr];
  // room for a full burst of results
  assign room = (count <= (AW+1)'(DEPTH - PUSH_MAX));

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(push.n);
      rptr  <= rptr + AW'(pop);
      count <= count + (AW+1)'(push.n) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (PUSH_CNT_W'(k) < push.n) begin
        slots[wptr + AW'(k)] <= push.ent[k];
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(DEPTH))
    else $error("result queue overflow");

  a_push_needs_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != '0) |-> room)
    else $error("results pushed without room");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && push.n == '0) |=> (count == $past(count) - 1'b1))
    else $error("pop did not lower the count");

endmodule

`default_nettype wire

FILE: design/grid_local_peak_detector.sv
`timescale 1ns / 1ps
`default_nettype none

// four-neighbour local maximum detector over a streamed frame
// pixels enter on the in channel (in_valid/in_ready, signed pixel), one beat per pixel,
// row-major; every pixel that is >= each of its existing up, down, left and right
// neighbours is reported on the out channel as (peak_row, peak_col, last_of_run)
// a pixel is decided when its last neighbour arrives: its down neighbour for inner
// rows, its right neighbour in the last row; the final pixel decides itself, so one
// input beat yields zero to three result beats; last_of_run marks the final one
// frame_rows (offset 0) and frame_cols (offset 4) set the frame size; a write to either
// restarts the frame at row 0, column 0; the user must write only while idle (unenforced)
// throughput: one pixel per cycle while the queue has room, set by the single line-buffer
// write port and the one-column-ahead read that feeds the window cells
// a pixel's results are in the result queue in the cycle after its beat is accepted
// results wait in an eight-entry queue; in_ready drops while fewer than three
// entries are free, so a stalled receiver stops the pixel stream before the queue overflows
// reset clears the counters and the queue and sets both registers to 1024; the line
// buffer needs no clearing pass since entries not written this frame never decide a peak
module grid_local_peak_detector #(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  // apb configuration port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [2:0]                    paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // pixel channel
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire signed [PIXEL_BITS-1:0]  pixel,
  // result channel
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [9:0]                   peak_row,
  output logic [9:0]                   peak_col,
  output logic                         last_of_run
);

  import glpd_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int NCELL = 3;

  // configuration registers, raw and as used
  logic [CFG_W-1:0]   frame_rows;
  logic [CFG_W-1:0]   frame_cols;
  logic [ROW_W-1:0]   rows_last;
  logic [COL_W-1:0]   cols_last;

  // position of the next pixel
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;

  logic               cfg_write;
  glpd_reg_t          cfg_sel;
  logic               accept;
  logic               room;

  // line buffer word: row above in the upper half, two rows above in the lower half
  logic [2*PIXEL_BITS-1:0] rd_word;
  logic [COL_W-1:0]        rd_addr;
  logic [COL_W:0]          col_plus2;

  // window cells: 0 is column c, 1 is column c-1, 2 is column c-2
  logic signed [PIXEL_BITS-1:0] c_top [NCELL];
  logic signed [PIXEL_BITS-1:0] c_mid [NCELL];
  logic signed [PIXEL_BITS-1:0] c_bot [NCELL];

  logic signed [PIXEL_BITS-1:0] up_c;
  logic signed [PIXEL_BITS-1:0] up2_c;
  logic signed [PIXEL_BITS-1:0] up_l;
  logic signed [PIXEL_BITS-1:0] up_r;
  logic signed [PIXEL_BITS-1:0] prev;
  logic signed [PIXEL_BITS-1:0] prev2;

  logic                          last_row;
  logic [PUSH_MAX-1:0]           hit;
  glpd_result_t [PUSH_MAX-1:0]   cand;
  glpd_push_t                    push;
  glpd_result_t                  head;

  // ---------------------------------------------------------------- config port
  assign pready = 1'b1;
  assign cfg_sel = glpd_reg_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    unique case (cfg_sel)
      REG_FRAME_ROWS: prdata = 32'(frame_rows);
      REG_FRAME_COLS: prdata = 32'(frame_cols);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- counters
  assign in_ready = room;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= CFG_RESET;
      frame_cols <= CFG_RESET;
      rows_last  <= ROW_W'(clamp_count(CFG_RESET, 32'(MAX_ROWS)) - 32'd1);
      cols_last  <= COL_W'(clamp_count(CFG_RESET, 32'(MAX_COLS)) - 32'd1);
      row        <= '0;
      col        <= '0;
    end else if (cfg_write) begin
      // any register write restarts the frame
      if (cfg_sel == REG_FRAME_ROWS) begin
        frame_rows <= pwdata[CFG_W-1:0];
        rows_last  <= ROW_W'(clamp_count(pwdata[CFG_W-1:0], 32'(MAX_ROWS)) - 32'd1);
      end else begin
        frame_cols <= pwdata[CFG_W-1:0];
        cols_last  <= COL_W'(clamp_count(pwdata[CFG_W-1:0], 32'(MAX_COLS)) - 32'd1);
      end
      row <= '0;
      col <= '0;
    end else if (accept) begin
      if (col == cols_last) begin
        col <= '0;
        row <= (row == rows_last) ? '0 : row + ROW_W'(1);
      end else begin
        col <= col + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- line buffer
  // fetch two columns ahead, wrapping into the next row; the read data
  // register is the right-hand neighbour column of the window
  always_comb begin
    col_plus2 = {1'b0, col} + (COL_W+1)'(2);
    if (col_plus2 > {1'b0, cols_last}) begin
      rd_addr = COL_W'(col_plus2 - {1'b0, cols_last} - (COL_W+1)'(1));
    end else begin
      rd_addr = col_plus2[COL_W-1:0];
    end
  end

  glpd_line_buf #(
    .DEPTH(MAX_COLS),
    .WIDTH(2*PIXEL_BITS)
  ) u_line_buf (
    .clk   (clk),
    .we    (accept),
    .waddr (col),
    .wdata ({pixel, up_c}),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_word)
  );

  // ---------------------------------------------------------------- window cells
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_head
      // column c is loaded from the prefetched column c+1
      glpd_col_cell #(.W(PIXEL_BITS)) u_cell (
        .clk    (clk),
        .shift  (accept),
        .top_in (rd_word[PIXEL_BITS-1:0]),
        .mid_in (rd_word[2*PIXEL_BITS-1:PIXEL_BITS]),
        .bot_in (pixel),
        .top    (c_top[k]),
        .mid    (c_mid[k]),
        .bot    (c_bot[k])
      );
    end else if (k == 1) begin : g_left
      // the incoming pixel lands in the column it belongs to
      glpd_col_cell #(.W(PIXEL_BITS)) u_cell (
        .clk    (clk),
        .shift  (accept),
        .top_in (c_top[k-1]),
        .mid_in (c_mid[k-1]),
        .bot_in (pixel),
        .top    (c_top[k]),
        .mid    (c_mid[k]),
        .bot    (c_bot[k])
      );
    end else begin : g_tail
      glpd_col_cell #(.W(PIXEL_BITS)) u_cell (
        .clk    (clk),
        .shift  (accept),
        .top_in (c_top[k-1]),
        .mid_in (c_mid[k-1]),
        .bot_in (c_bot[k-1]),
        .top    (c_top[k]),
        .mid    (c_mid[k]),
        .bot    (c_bot[k])
      );
    end
  end

  // ---------------------------------------------------------------- decisions
  assign up_c  = c_mid[0];                               // row r-1, column c
  assign up2_c = c_top[0];                               // row r-2, column c
  assign up_l  = c_mid[1];                               // row r-1, column c-1
  assign up_r  = rd_word[2*PIXEL_BITS-1:PIXEL_BITS];     // row r-1, column c+1
  assign prev  = c_bot[1];                               // row r, column c-1
  assign prev2 = c_bot[2];                               // row r, column c-2

  assign last_row = (row == rows_last);

  always_comb begin
    // pixel above, now that its down neighbour is here
    hit[0] = (row != '0) && (row == ROW_W'(1) || up_c >= up2_c) && (up_c >= pixel) &&
             (col == '0 || up_c >= up_l) && (col == cols_last || up_c >= up_r);
    // last row: pixel to the left, now that its right neighbour is here
    hit[1] = last_row && (col != '0) && (prev >= up_l) && (prev >= pixel) &&
             (col == COL_W'(1) || prev >= prev2);
    // final pixel of the frame
    hit[2] = last_row && (col == cols_last) && (pixel >= up_c) && (pixel >= prev);

    cand[0].row  = RES_W'(row - ROW_W'(1));
    cand[0].col  = RES_W'(col);
    cand[0].last = hit[0] && !hit[1] && !hit[2];
    cand[1].row  = RES_W'(row);
    cand[1].col  = RES_W'(col - COL_W'(1));
    cand[1].last = hit[1] && !hit[2];
    cand[2].row  = RES_W'(row);
    cand[2].col  = RES_W'(col);
    cand[2].last = hit[2];
  end

  // pack the hits in order
  always_comb begin
    push = '0;
    for (int k = 0; k < PUSH_MAX; k++) begin
      if (hit[k]) begin
        push.ent[push.n] = cand[k];
        push.n = push.n + PUSH_CNT_W'(1);
      end
    end
    if (!accept) begin
      push.n = '0;
    end
  end

  // ---------------------------------------------------------------- result queue
  glpd_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  assign peak_row    = head.row;
  assign peak_col    = head.col;
  assign last_of_run = head.last;

  a_pos_in_frame: assert property (@(posedge clk) disable iff (rst)
    (col <= cols_last) && (row <= rows_last))
    else $error("position counter left the frame");

endmodule

`default_nettype wire
